[design/brr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and codes of the bilinear RGB resampler.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int COORD_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int SRC_REG_W = 9;
  localparam int TGT_REG_W = 13;
  localparam int TARGET_LIMIT = 4096;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       coord_error;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_POS, S_RD0, S_RD1, S_RD2, S_RD3, S_CAP, S_LERPH, S_LERPV, S_OUT
  } state_t;

endpackage

[design/brr_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brr_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface brr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/bilinear_rgb_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_rgb_resampler
// Align-corners bilinear resize of an RGB frame held in an internal store.
// ----------------------------------------------------------------------------
// A load word (operation 0) writes one 24-bit pixel into the frame store at
// row*MAX_SOURCE_WIDTH + column; loads outside the store are dropped. A
// sample word (operation 1) yields one result word. A sample inside the
// target frame holds off the input while one restoring divider per axis
// retires one quotient bit a cycle, then four reads of the frame memory fetch
// the neighbours, and two multiply stages blend them. Its result word becomes
// valid in the same cycle that the input is ready again. A sample outside
// the target frame goes straight to S_OUT, from which the output register
// shows coord_error with zero colors, and the input is ready again as that
// result becomes valid. Either path waits in S_OUT while the output register
// still holds an unaccepted result. The result sits in an output register, so
// loads and the next sample are taken while a finished result waits. The user
// must write configuration only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module bilinear_rgb_resampler
  import brr_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int FRACTION_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  brr_stream_if.sink           pix_in,
  brr_stream_if.source         pix_out
);

  localparam int F     = FRACTION_BITS;
  localparam int XB    = $clog2(MAX_SOURCE_WIDTH);
  localparam int YB    = $clog2(MAX_SOURCE_HEIGHT);
  localparam int SB    = (XB > YB) ? XB : YB;
  localparam int NW    = 2 * COORD_W;          // coord * (size-1)
  localparam int XW    = NW + F;               // dividend width
  localparam int QW    = SB + F;               // quotient width
  localparam int CW    = $clog2(QW + 1);
  localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = 8 + F + 1;            // horizontal blend
  localparam int VW    = 2 * F + 10;           // vertical blend

  // configuration registers
  logic [SRC_REG_W-1:0] source_width, source_height;
  logic [TGT_REG_W-1:0] target_width, target_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_REG_W'(256);
      source_height <= SRC_REG_W'(256);
      target_width  <= TGT_REG_W'(256);
      target_height <= TGT_REG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_REG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_REG_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_REG_W-1:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[TGT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated to their legal ranges
  function automatic logic [12:0] sat(input logic [12:0] v, input logic [12:0] hi);
    if (v == 13'd0) return 13'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [12:0] sw, sh, tw, th;
  assign sw = sat(13'(source_width),  13'(MAX_SOURCE_WIDTH));
  assign sh = sat(13'(source_height), 13'(MAX_SOURCE_HEIGHT));
  assign tw = sat(target_width,  13'(TARGET_LIMIT));
  assign th = sat(target_height, 13'(TARGET_LIMIT));

  // frame memory
  logic [23:0]   mem [DEPTH];
  logic [23:0]   rdata;
  logic [AW-1:0] raddr;
  logic          rd_en;

  state_t state, state_next;
  in_word_t w;
  logic acc;

  assign w   = pix_in.data;
  assign acc = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (state == S_IDLE);

  logic load_ok;
  assign load_ok = acc && (w.operation == OP_LOAD) &&
                   ({1'b0, w.coord_x} < 13'(MAX_SOURCE_WIDTH)) &&
                   ({1'b0, w.coord_y} < 13'(MAX_SOURCE_HEIGHT));

  always_ff @(posedge clk) begin
    if (load_ok)
      mem[AW'(w.coord_y) * AW'(MAX_SOURCE_WIDTH) + AW'(w.coord_x)] <=
        {w.pixel_red, w.pixel_green, w.pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[raddr];
  end

  // divider and sample datapath registers
  logic [QW-1:0] xnum, ynum;
  logic [12:0]   xrem, yrem;
  logic [11:0]   xden, yden;
  logic [QW-1:0] xq, yq;
  logic [CW-1:0] cnt;
  logic [12:0]   swm1, shm1;
  logic [12:0]   x0, x1, y0, y1;
  logic [F-1:0]  fx, fy;
  logic [23:0]   p00, p10, p01, p11;
  logic [HW-1:0] top [3];
  logic [HW-1:0] bot [3];
  logic [VW-1:0] vsum [3];
  logic          err;
  out_word_t     res;
  logic          out_valid;

  logic is_err;
  assign is_err = ({1'b0, w.coord_x} >= tw) || ({1'b0, w.coord_y} >= th);

  // full dividends; a target size of one maps to zero
  logic [XW-1:0] xdvd, ydvd;
  assign xdvd = (tw <= 13'd1) ? '0 : XW'(NW'(w.coord_x) * NW'(sw - 13'd1)) << F;
  assign ydvd = (th <= 13'd1) ? '0 : XW'(NW'(w.coord_y) * NW'(sh - 13'd1)) << F;

  // one restoring step per axis
  logic [12:0] xsh, ysh;
  assign xsh = {xrem[11:0], xnum[QW-1]};
  assign ysh = {yrem[11:0], ynum[QW-1]};

  // integer part clamped to the last column or row
  logic [12:0] ix, iy, cx0, cy0;
  assign ix  = 13'(xq[QW-1:F]);
  assign iy  = 13'(yq[QW-1:F]);
  assign cx0 = (ix > swm1) ? swm1 : ix;
  assign cy0 = (iy > shm1) ? shm1 : iy;

  function automatic logic [AW-1:0] addr(input logic [12:0] x, input logic [12:0] y);
    return AW'(y) * AW'(MAX_SOURCE_WIDTH) + AW'(x);
  endfunction

  always_comb begin
    rd_en = 1'b1;
    case (state)
      S_RD0:   raddr = addr(x0, y0);
      S_RD1:   raddr = addr(x1, y0);
      S_RD2:   raddr = addr(x0, y1);
      S_RD3:   raddr = addr(x1, y1);
      default: begin
        raddr = addr(x0, y0);
        rd_en = 1'b0;
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || pix_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc && w.operation == OP_SAMPLE) state_next = is_err ? S_OUT : S_DIV;
      S_DIV:   if (cnt == CW'(1)) state_next = S_POS;
      S_POS:   state_next = S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_CAP;
      S_CAP:   state_next = S_LERPH;
      S_LERPH: state_next = S_LERPV;
      S_LERPV: state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  logic [F:0] one_q;
  assign one_q = (F + 1)'(1) << F;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // start both divisions; seed the remainder with the dividend bits
        // above the quotient, which always lie below the divisor
        err  <= is_err;
        swm1 <= sw - 13'd1;
        shm1 <= sh - 13'd1;
        cnt  <= CW'(QW);
        xden <= (tw <= 13'd1) ? 12'd1 : 12'(tw - 13'd1);
        yden <= (th <= 13'd1) ? 12'd1 : 12'(th - 13'd1);
        xnum <= xdvd[QW-1:0];
        ynum <= ydvd[QW-1:0];
        xrem <= 13'(xdvd >> QW);
        yrem <= 13'(ydvd >> QW);
        xq   <= '0;
        yq   <= '0;
      end
      S_DIV: begin
        cnt <= cnt - CW'(1);
        xnum <= xnum << 1;
        ynum <= ynum << 1;
        if (xsh >= {1'b0, xden}) begin
          xrem <= xsh - {1'b0, xden};
          xq   <= {xq[QW-2:0], 1'b1};
        end else begin
          xrem <= xsh;
          xq   <= {xq[QW-2:0], 1'b0};
        end
        if (ysh >= {1'b0, yden}) begin
          yrem <= ysh - {1'b0, yden};
          yq   <= {yq[QW-2:0], 1'b1};
        end else begin
          yrem <= ysh;
          yq   <= {yq[QW-2:0], 1'b0};
        end
      end
      S_POS: begin
        x0 <= cx0;
        y0 <= cy0;
        x1 <= (cx0 + 13'd1 < swm1 + 13'd1) ? cx0 + 13'd1 : swm1;
        y1 <= (cy0 + 13'd1 < shm1 + 13'd1) ? cy0 + 13'd1 : shm1;
        fx <= xq[F-1:0];
        fy <= yq[F-1:0];
      end
      S_RD1: p00 <= rdata;
      S_RD2: p10 <= rdata;
      S_RD3: p01 <= rdata;
      S_CAP: p11 <= rdata;
      S_LERPH: begin
        for (int c = 0; c < 3; c++) begin
          top[c] <= HW'(p00[16-8*c +: 8]) * HW'(one_q - (F + 1)'(fx)) +
                    HW'(p10[16-8*c +: 8]) * HW'(fx);
          bot[c] <= HW'(p01[16-8*c +: 8]) * HW'(one_q - (F + 1)'(fx)) +
                    HW'(p11[16-8*c +: 8]) * HW'(fx);
        end
      end
      S_LERPV: begin
        for (int c = 0; c < 3; c++)
          vsum[c] <= VW'(top[c]) * VW'(one_q - (F + 1)'(fy)) + VW'(bot[c]) * VW'(fy);
      end
      default: ;
    endcase
  end

  // round half up and clamp
  function automatic logic [7:0] rnd(input logic [VW-1:0] v);
    logic [VW-1:0] r;
    r = (v + (VW'(1) << (2 * F - 1))) >> (2 * F);
    return (r > VW'(255)) ? 8'd255 : r[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      res.coord_error <= err;
      res.out_red     <= err ? 8'd0 : rnd(vsum[0]);
      res.out_green   <= err ? 8'd0 : rnd(vsum[1]);
      res.out_blue    <= err ? 8'd0 : rnd(vsum[2]);
    end
  end

  assign pix_out.valid = out_valid;
  assign pix_out.data  = res;

endmodule

[tb/bilinear_rgb_resampler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_rgb_resampler_tb
// Self-checking bench for the bilinear RGB resampler.
// ----------------------------------------------------------------------------
// Load words fill the frame store, sample words are checked against an
// in-bench align-corners bilinear predictor. Sampling only touches pixels of
// the current source frame that were loaded earlier. The bench walks several
// frame and target sizes, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bilinear_rgb_resampler_tb;
  import brr_pkg::*;

  localparam int SRC_MAX  = 256;
  localparam int FRAC     = 16;
  localparam int MAX_CYC  = 2000000;
  localparam int LATENCY  = 60;

  // Frame store mirror and the pixel blend predictor.
  class resample_scoreboard;
    logic [23:0] pixels [int];
    int unsigned src_w, src_h, tgt_w, tgt_h;
    out_word_t   pending [$];
    int          errors;

    function new();
      src_w = 256; src_h = 256; tgt_w = 256; tgt_h = 256; errors = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned src_pos(int unsigned c, int unsigned s, int unsigned d);
      if (d <= 1) return 0;
      return ((longint'(c) * longint'(s - 1)) << FRAC) / longint'(d - 1);
    endfunction

    function logic [23:0] pix(int unsigned x, int unsigned y);
      int a;
      a = y * SRC_MAX + x;
      return pixels.exists(a) ? pixels[a] : 24'h0;
    endfunction

    // Note an accepted word: update the store or queue a predicted result.
    function void note_word(in_word_t w);
      int unsigned sw, sh, tw, th, x0, x1, y0, y1;
      longint unsigned px, py, fx, fy, one, top, bot, v;
      logic [23:0] p00, p10, p01, p11;
      logic [7:0] ch [3];
      out_word_t r;
      if (w.operation == OP_LOAD) begin
        if (w.coord_x < SRC_MAX && w.coord_y < SRC_MAX)
          pixels[w.coord_y * SRC_MAX + w.coord_x] = {w.pixel_red, w.pixel_green, w.pixel_blue};
        return;
      end
      sw = clip(src_w, SRC_MAX); sh = clip(src_h, SRC_MAX);
      tw = clip(tgt_w, TARGET_LIMIT); th = clip(tgt_h, TARGET_LIMIT);
      if (w.coord_x >= tw || w.coord_y >= th) begin
        r = '0; r.coord_error = 1'b1;
        pending = {pending, r};
        return;
      end
      one = 64'd1 << FRAC;
      px = src_pos(w.coord_x, sw, tw); py = src_pos(w.coord_y, sh, th);
      x0 = 32'(px >> FRAC); y0 = 32'(py >> FRAC);
      if (x0 > sw - 1) x0 = sw - 1;
      if (y0 > sh - 1) y0 = sh - 1;
      fx = px & (one - 1); fy = py & (one - 1);
      x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
      p00 = pix(x0, y0); p10 = pix(x1, y0); p01 = pix(x0, y1); p11 = pix(x1, y1);
      for (int c = 0; c < 3; c++) begin
        top = p00[16-8*c +: 8] * (one - fx) + p10[16-8*c +: 8] * fx;
        bot = p01[16-8*c +: 8] * (one - fx) + p11[16-8*c +: 8] * fx;
        v = top * (one - fy) + bot * fy;
        v = (v + (64'd1 << (2*FRAC - 1))) >> (2*FRAC);
        ch[c] = (v > 255) ? 8'd255 : v[7:0];
      end
      r.out_red = ch[0]; r.out_green = ch[1]; r.out_blue = ch[2]; r.coord_error = 1'b0;
      pending = {pending, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_red !== e.out_red) begin
        $error("out_red expected %0d got %0d", e.out_red, got.out_red); errors++;
      end
      if (got.out_green !== e.out_green) begin
        $error("out_green expected %0d got %0d", e.out_green, got.out_green); errors++;
      end
      if (got.out_blue !== e.out_blue) begin
        $error("out_blue expected %0d got %0d", e.out_blue, got.out_blue); errors++;
      end
      if (got.coord_error !== e.coord_error) begin
        $error("coord_error expected %0d got %0d", e.coord_error, got.coord_error);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  brr_stream_if #(.payload_t(in_word_t))  pix_in ();
  brr_stream_if #(.payload_t(out_word_t)) pix_out ();

  bilinear_rgb_resampler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  resample_scoreboard sb = new();
  int  cycles = 0;
  int  hold_req = 0;       // count of long receiver stalls requested by the stimulus
  int  stall_mode = 0;     // 0 never stall, 1 occasional stall, 2 frequent stall
  // Shadow of the current source frame size, after saturation.
  int unsigned cur_sw, cur_sh;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Score the output channel at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && pix_out.valid && pix_out.ready) sb.check_result(pix_out.data);
    if (cycles > MAX_CYC) begin
      $display("bilinear_rgb_resampler: mismatch");
      $finish;
    end
  end

  // Receiver: its own stall pattern, stretches without stalls, long hold-off.
  initial begin
    int hold;
    int hold_seen;
    pix_out.ready = 1'b0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        pix_out.ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      pix_out.ready <= (stall_mode == 0) ? 1'b1 :
                       (stall_mode == 1) ? ($urandom_range(0, 3) != 0) :
                       ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one word and hold it until accepted; random gap after a burst.
  task automatic push_word(in_word_t w);
    pix_in.data  <= w;
    pix_in.valid <= 1'b1;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_word(w);
    @(negedge clk);
    if ($urandom_range(0, 7) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    pix_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Hold the write enable; the caller drops it after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_W-1:0];
    @(negedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  sb.src_w = v & 9'h1FF;
      REG_SOURCE_HEIGHT: sb.src_h = v & 9'h1FF;
      REG_TARGET_WIDTH:  sb.tgt_w = v & 13'h1FFF;
      default:           sb.tgt_h = v & 13'h1FFF;
    endcase
  endtask

  function automatic in_word_t load_word(int unsigned x, int unsigned y);
    in_word_t w;
    w.operation = OP_LOAD; w.coord_x = 12'(x); w.coord_y = 12'(y);
    w.pixel_red = 8'($urandom); w.pixel_green = 8'($urandom); w.pixel_blue = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t sample_word(int unsigned x, int unsigned y);
    in_word_t w;
    w = '0;
    w.operation = OP_SAMPLE; w.coord_x = 12'(x); w.coord_y = 12'(y);
    w.pixel_red = 8'($urandom); w.pixel_green = 8'($urandom); w.pixel_blue = 8'($urandom);
    return w;
  endfunction

  // Set all four sizes, then fill the whole source frame so samples read
  // only loaded pixels. Raw register values may lie outside the legal range.
  task automatic set_phase(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
    drain_results();
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    cfg_we <= 1'b0;
    cur_sw = sb.clip(sb.src_w, SRC_MAX);
    cur_sh = sb.clip(sb.src_h, SRC_MAX);
    for (int y = 0; y < cur_sh; y++)
      for (int x = 0; x < cur_sw; x++) push_word(load_word(x, y));
  endtask

  task automatic random_samples(int n);
    int unsigned tw, th;
    tw = sb.clip(sb.tgt_w, TARGET_LIMIT);
    th = sb.clip(sb.tgt_h, TARGET_LIMIT);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push_word(sample_word($urandom_range(0, 4095), $urandom_range(0, 4095)));
        // Reload an in-frame pixel, or drop a load outside the store.
        1: push_word(load_word($urandom_range(0, cur_sw - 1), $urandom_range(0, cur_sh - 1)));
        2: push_word(load_word($urandom_range(SRC_MAX, 4095), $urandom_range(0, 4095)));
        default: push_word(sample_word($urandom_range(0, tw - 1), $urandom_range(0, th - 1)));
      endcase
    end
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: tiny frame, corners, errors, loads outside the store.
    set_phase(2, 2, 3, 3);
    push_word(sample_word(0, 0));
    push_word(sample_word(2, 2));
    push_word(sample_word(1, 1));
    push_word(sample_word(3, 0));
    push_word(sample_word(0, 3));
    push_word(sample_word(4095, 4095));
    push_word(load_word(4095, 4095));
    push_word(load_word(100, 100));   // outside frame, inside store
    push_word('{operation: OP_LOAD, coord_x: 1, coord_y: 0,
                pixel_red: 8'hFF, pixel_green: 8'h00, pixel_blue: 8'hFF});
    push_word(sample_word(1, 0));
    // Single-pixel target and zero-valued registers saturate to one.
    set_phase(0, 0, 0, 0);
    push_word(sample_word(0, 0));
    push_word(sample_word(1, 0));
    // Equal sizes give an identity mapping.
    set_phase(4, 4, 4, 4);
    for (int i = 0; i < 4; i++) push_word(sample_word(i, 3 - i));

    // Fill the output register while the receiver holds off.
    hold_req++;
    random_samples(40);
    drain_results();

    // Random phases over several size settings, the extremes among them.
    set_phase(5, 3, 17, 9);        random_samples(200);
    set_phase(511, 1, 4095, 2);    random_samples(200);
    set_phase(3, 7, 8191, 8191);   random_samples(200);
    set_phase(8, 8, 1, 4096);      random_samples(200);
    set_phase(12, 10, 5, 3);       random_samples(280);
    set_phase(1, 16, 2, 31);       random_samples(200);

    drain_results();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bilinear_rgb_resampler: match");
    end else begin
      $display("bilinear_rgb_resampler: mismatch");
    end
    $finish;
  end

endmodule

[bilinear_rgb_resampler.f]
design/brr_pkg.sv
design/brr_stream_if.sv
design/bilinear_rgb_resampler.sv
tb/bilinear_rgb_resampler_tb.sv
